### src/move_history_killer_table_macros.svh
// ----------------------------------------------------------------------------
// move_history_killer_table_macros
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef MOVE_HISTORY_KILLER_TABLE_MACROS_SVH
`define MOVE_HISTORY_KILLER_TABLE_MACROS_SVH

// same-cycle implication
`define MHKT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MHKT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/mhkt_pkg.sv
// ----------------------------------------------------------------------------
// mhkt_pkg
// Types, constants and helpers of the move history / killer table engine.
// ----------------------------------------------------------------------------
package mhkt_pkg;

   localparam int MOVE_W       = 16;
   localparam int SCORE_W      = 32;
   localparam int SQ_W         = 6;
   localparam int PIECE_W      = 3;
   localparam int DEPTH_W      = 7;
   localparam int PLY_W        = 7;
   localparam int PIECE_KINDS  = 6;
   localparam int SQUARE_COUNT = 64;

   localparam int SFT_AW = 1 + 2 * SQ_W;
   localparam int PT_AW  = PIECE_W + SQ_W;
   localparam int CM_AW  = 2 * SQ_W;

   typedef logic [MOVE_W-1:0]         move_type;
   typedef logic signed [SCORE_W-1:0] score_type;

   localparam score_type SCORE_MAX = 32'sh7fff_ffff;
   localparam score_type SCORE_MIN = 32'sh8000_0000;

   typedef enum logic [1:0] {
      ACT_ADD_BONUS = 2'd0,
      ACT_FAIL_HIGH = 2'd1,
      ACT_LOOKUP    = 2'd2,
      ACT_CLEAR     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_UPDATE
   } state_type;

   function automatic score_type sat_add(input score_type a, input score_type b);
      logic signed [SCORE_W:0] sum;
      sum = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
      if (sum[SCORE_W] != sum[SCORE_W-1]) begin
         return sum[SCORE_W] ? SCORE_MIN : SCORE_MAX;
      end
      return sum[SCORE_W-1:0];
   endfunction

endpackage

### src/mhkt_ifs.sv
// ----------------------------------------------------------------------------
// mhkt_ifs
// Valid/ready channels carrying request and response items.
// ----------------------------------------------------------------------------
interface mhkt_req_if;
   import mhkt_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          action;
   logic [MOVE_W-1:0]   move_word;
   logic [MOVE_W-1:0]   prev_move_word;
   logic                side;
   logic [PIECE_W-1:0]  piece;
   logic signed [SCORE_W-1:0] bonus;
   logic [DEPTH_W-1:0]  depth;
   logic [PLY_W-1:0]    ply;
   logic                killer_index;

   modport source (output valid, action, move_word, prev_move_word, side, piece,
                   bonus, depth, ply, killer_index, input ready);
   modport sink   (input valid, action, move_word, prev_move_word, side, piece,
                   bonus, depth, ply, killer_index, output ready);
endinterface

interface mhkt_rsp_if;
   import mhkt_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [SCORE_W-1:0] history_score;
   logic signed [SCORE_W-1:0] pt_score;
   logic [MOVE_W-1:0]         killer_move;
   logic                      killer_hit;
   logic [MOVE_W-1:0]         counter_move;

   modport source (output valid, history_score, pt_score, killer_move, killer_hit,
                   counter_move, input ready);
   modport sink   (input valid, history_score, pt_score, killer_move, killer_hit,
                   counter_move, output ready);
endinterface

### src/move_history_killer_table.sv
// ----------------------------------------------------------------------------
// move_history_killer_table - history, killer and countermove table engine
// One item at a time (memory read at accept, then modify and write back once the
// result register is free). Clear and reset sweep all stores, no item taken
// meanwhile; a clear item answers with zero scores and moves after its sweep.
// ----------------------------------------------------------------------------
module move_history_killer_table #(
   parameter int KILLER_SLOTS = 2,
   parameter int MAX_PLY      = 128
) (
   input  logic         clock,
   input  logic         reset,
   mhkt_req_if.sink     req_chan,
   mhkt_rsp_if.source   rsp_chan
);
   import mhkt_pkg::*;

   localparam int KROW_AW = $clog2(MAX_PLY);
   localparam int KS_IW   = (KILLER_SLOTS > 1) ? $clog2(KILLER_SLOTS) : 1;

   typedef logic [KILLER_SLOTS-1:0][MOVE_W-1:0] krow_type;

   // storage
   score_type sft_mem [2**SFT_AW];
   score_type pt_mem  [2**PT_AW];
   move_type  cm_mem  [2**CM_AW];
   krow_type  km_mem  [MAX_PLY];

   // control
   state_type           state_ff, state_in;
   logic [SFT_AW-1:0]   sweep_cnt_ff;
   logic                reply_ff;
   logic                rsp_valid_ff, rsp_valid_in;

   // item registers
   action_type          action_ff;
   move_type            move_ff;
   move_type            prev_ff;
   logic                side_ff;
   logic [PIECE_W-1:0]  piece_ff;
   score_type           amount_ff, amount_in;
   logic [PLY_W-1:0]    ply_ff;
   logic                kidx_ff;

   // read data
   score_type           sft_rdata_ff;
   score_type           pt_rdata_ff;
   move_type            cm_rdata_ff;
   krow_type            km_rdata_ff;

   // response payload
   score_type           hist_ff, hist_in;
   score_type           pscore_ff, pscore_in;
   move_type            kmove_ff, kmove_in;
   logic                khit_ff, khit_in;
   move_type            cmove_ff, cmove_in;

   logic                accept, rd_en, sweep_en, do_update, out_free, sweep_last;
   action_type          req_action;
   logic [2*DEPTH_W-1:0] depth_sq;
   logic [SFT_AW-1:0]   sft_raddr, sft_waddr;
   logic [PT_AW-1:0]    pt_raddr, pt_waddr;
   logic [CM_AW-1:0]    cm_raddr, cm_waddr;
   logic [KROW_AW-1:0]  km_raddr, km_waddr;
   logic [8:0]          req_ply_ext, ply_ext;
   logic                sft_we, pt_we, cm_we, km_we;
   score_type           sft_wdata, pt_wdata, sft_new, pt_new;
   move_type            cm_wdata;
   krow_type            km_wdata, row_shift, row_cur;
   logic                is_upd, is_fh, piece_ok, ply_ok, kidx_ok;
   logic                hit_old, hit_new, krow_we_upd, sweep_krow_ok;
   logic [KS_IW-1:0]    kidx_sel;

   assign req_action = action_type'(req_chan.action);
   assign accept     = req_chan.valid & req_chan.ready;
   assign out_free   = ~rsp_valid_ff | rsp_chan.ready;
   assign sweep_last = &sweep_cnt_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_SWEEP: begin
            if (sweep_last) state_in = reply_ff ? ST_UPDATE : ST_IDLE;
         end
         ST_IDLE: begin
            if (req_chan.valid) state_in = (req_action == ACT_CLEAR) ? ST_SWEEP : ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_SWEEP;
      endcase
   end

   // state outputs
   always_comb begin
      req_chan.ready = 1'b0;
      sweep_en       = 1'b0;
      do_update      = 1'b0;
      unique case (state_ff)
         ST_SWEEP:  sweep_en       = 1'b1;
         ST_IDLE:   req_chan.ready = 1'b1;
         ST_UPDATE: do_update      = out_free;
         default:   sweep_en       = 1'b0;
      endcase
   end

   assign rd_en = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_cnt_ff <= '0;
         reply_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (sweep_en) sweep_cnt_ff <= sweep_cnt_ff + SFT_AW'(1);
         if (accept)   reply_ff     <= (req_action == ACT_CLEAR);
      end
   end

   // item capture
   assign depth_sq  = (2*DEPTH_W)'(req_chan.depth) * (2*DEPTH_W)'(req_chan.depth);
   assign amount_in = (req_action == ACT_FAIL_HIGH) ?
                      score_type'({{(SCORE_W-2*DEPTH_W){1'b0}}, depth_sq}) : req_chan.bonus;

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         move_ff   <= req_chan.move_word;
         prev_ff   <= req_chan.prev_move_word;
         side_ff   <= req_chan.side;
         piece_ff  <= req_chan.piece;
         amount_ff <= amount_in;
         ply_ff    <= req_chan.ply;
         kidx_ff   <= req_chan.killer_index;
      end
   end

   // read addresses
   assign req_ply_ext = {2'b00, req_chan.ply};
   assign sft_raddr = {req_chan.side, req_chan.move_word[SQ_W-1:0],
                       req_chan.move_word[2*SQ_W-1:SQ_W]};
   assign pt_raddr  = {req_chan.piece, req_chan.move_word[2*SQ_W-1:SQ_W]};
   assign cm_raddr  = {req_chan.prev_move_word[SQ_W-1:0],
                       req_chan.prev_move_word[2*SQ_W-1:SQ_W]};
   assign km_raddr  = req_ply_ext[KROW_AW-1:0];

   // modify
   assign ply_ext   = {2'b00, ply_ff};
   assign is_fh     = (action_ff == ACT_FAIL_HIGH);
   assign is_upd    = (action_ff == ACT_ADD_BONUS) | is_fh;
   assign piece_ok  = ({1'b0, piece_ff} < 4'(PIECE_KINDS));
   assign ply_ok    = (ply_ext < 9'(MAX_PLY));
   assign kidx_ok   = ({3'b000, kidx_ff} < 4'(KILLER_SLOTS));
   assign kidx_sel  = KS_IW'(kidx_ff);
   assign sft_new   = sat_add(sft_rdata_ff, amount_ff);
   assign pt_new    = sat_add(pt_rdata_ff, amount_ff);

   always_comb begin
      hit_old   = 1'b0;
      row_shift = km_rdata_ff;
      for (int k = 0; k < KILLER_SLOTS; k++) begin
         if (km_rdata_ff[k] == move_ff) hit_old = 1'b1;
      end
      for (int k = 1; k < KILLER_SLOTS; k++) begin
         row_shift[k] = km_rdata_ff[k-1];
      end
      row_shift[0] = move_ff;
   end

   assign krow_we_upd = is_fh & ply_ok & ~hit_old;
   assign row_cur     = krow_we_upd ? row_shift : km_rdata_ff;

   always_comb begin
      hit_new = 1'b0;
      for (int k = 0; k < KILLER_SLOTS; k++) begin
         if (row_cur[k] == move_ff) hit_new = 1'b1;
      end
   end

   // after a clear every row is null, so only the null move hits
   always_comb begin
      if (action_ff == ACT_CLEAR) begin
         hist_in   = '0;
         pscore_in = '0;
         kmove_in  = '0;
         khit_in   = ply_ok & (move_ff == '0);
         cmove_in  = '0;
      end else begin
         hist_in   = is_upd ? sft_new : sft_rdata_ff;
         pscore_in = piece_ok ? (is_upd ? pt_new : pt_rdata_ff) : '0;
         kmove_in  = (ply_ok & kidx_ok) ? row_cur[kidx_sel] : '0;
         khit_in   = ply_ok & hit_new;
         cmove_in  = is_fh ? move_ff : cm_rdata_ff;
      end
   end

   assign rsp_valid_in = do_update | (rsp_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (do_update) begin
         hist_ff   <= hist_in;
         pscore_ff <= pscore_in;
         kmove_ff  <= kmove_in;
         khit_ff   <= khit_in;
         cmove_ff  <= cmove_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.history_score = hist_ff;
   assign rsp_chan.pt_score      = pscore_ff;
   assign rsp_chan.killer_move   = kmove_ff;
   assign rsp_chan.killer_hit    = khit_ff;
   assign rsp_chan.counter_move  = cmove_ff;

   // write back, or zero fill during a sweep
   assign sweep_krow_ok = (sweep_cnt_ff < SFT_AW'(MAX_PLY));
   assign sft_we = sweep_en | (do_update & is_upd);
   assign pt_we  = sweep_en | (do_update & is_upd & piece_ok);
   assign cm_we  = sweep_en | (do_update & is_fh);
   assign km_we  = (sweep_en & sweep_krow_ok) | (do_update & krow_we_upd);

   assign sft_waddr = sweep_en ? sweep_cnt_ff :
                      {side_ff, move_ff[SQ_W-1:0], move_ff[2*SQ_W-1:SQ_W]};
   assign pt_waddr  = sweep_en ? sweep_cnt_ff[PT_AW-1:0] :
                      {piece_ff, move_ff[2*SQ_W-1:SQ_W]};
   assign cm_waddr  = sweep_en ? sweep_cnt_ff[CM_AW-1:0] :
                      {prev_ff[SQ_W-1:0], prev_ff[2*SQ_W-1:SQ_W]};
   assign km_waddr  = sweep_en ? sweep_cnt_ff[KROW_AW-1:0] : ply_ext[KROW_AW-1:0];

   assign sft_wdata = sweep_en ? '0 : sft_new;
   assign pt_wdata  = sweep_en ? '0 : pt_new;
   assign cm_wdata  = sweep_en ? '0 : move_ff;
   assign km_wdata  = sweep_en ? '0 : row_shift;

   always_ff @(posedge clock) begin
      if (sft_we) sft_mem[sft_waddr] <= sft_wdata;
      if (rd_en)  sft_rdata_ff       <= sft_mem[sft_raddr];
   end

   always_ff @(posedge clock) begin
      if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
      if (rd_en) pt_rdata_ff      <= pt_mem[pt_raddr];
   end

   always_ff @(posedge clock) begin
      if (cm_we) cm_mem[cm_waddr] <= cm_wdata;
      if (rd_en) cm_rdata_ff      <= cm_mem[cm_raddr];
   end

   always_ff @(posedge clock) begin
      if (km_we) km_mem[km_waddr] <= km_wdata;
      if (rd_en) km_rdata_ff      <= km_mem[km_raddr];
   end

endmodule

### src/mhkt_checker.sv
// ----------------------------------------------------------------------------
// mhkt_checker
// Port-level checks of the table engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "move_history_killer_table_macros.svh"

module mhkt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_history_score,
   input logic [31:0] rsp_pt_score,
   input logic [15:0] rsp_killer_move,
   input logic        rsp_killer_hit,
   input logic [15:0] rsp_counter_move
);

   // one item in flight: no accept in the cycle after an accept
   `MHKT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "accept in back-to-back cycles")

   // a new result only appears from a busy cycle
   `MHKT_ASSERT_SAME(a_rsp_from_work, clock, reset, $rose(rsp_valid), $past(!req_ready), "result without work")

   // stalled result holds
   `MHKT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_history_score) && $stable(rsp_pt_score) && $stable(rsp_killer_move) && $stable(rsp_killer_hit) && $stable(rsp_counter_move), "stalled result changed")

endmodule

bind move_history_killer_table mhkt_checker u_mhkt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_history_score (rsp_chan.history_score),
   .rsp_pt_score      (rsp_chan.pt_score),
   .rsp_killer_move   (rsp_chan.killer_move),
   .rsp_killer_hit    (rsp_chan.killer_hit),
   .rsp_counter_move  (rsp_chan.counter_move)
);
